/* sv/kst_pkg.sv */
// ----------------------------------------------------------------------------
// kst_pkg
// Shared types, constants and helper functions of the keyboard scan code
// translator.
// ----------------------------------------------------------------------------
`default_nettype none

package kst_pkg;

  // Translation store geometry.
  localparam int STORE_DEPTH = 1024;
  localparam int STORE_AW    = $clog2(STORE_DEPTH);

  // Code ring geometry.
  localparam int RING_DEPTH = 16;
  localparam int RING_AW    = $clog2(RING_DEPTH);
  localparam int RING_CW    = $clog2(RING_DEPTH + 1);

  // Port field widths.
  localparam int ACT_W   = 2;
  localparam int SC_W    = 8;
  localparam int KEY_W   = 7;
  localparam int TADDR_W = 10;
  localparam int BYTE_W  = 8;
  localparam int CODE_W  = 16;
  localparam int SHIFT_W = 5;
  localparam int TSEL_W  = 3;
  localparam int COUNT_W = 5;

  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 48;

  // Transaction kinds carried on the input tuser.
  localparam logic [ACT_W-1:0] ACT_KEY   = 2'd0;
  localparam logic [ACT_W-1:0] ACT_WRITE = 2'd1;
  localparam logic [ACT_W-1:0] ACT_POP   = 2'd2;

  // Key numbers with special handling.
  localparam logic [KEY_W-1:0] KEY_LO_LAST  = 7'h51;
  localparam logic [KEY_W-1:0] KEY_HI_ONLY0 = 7'h35;
  localparam logic [KEY_W-1:0] KEY_HI_ONLY1 = 7'h3E;
  localparam logic [KEY_W-1:0] KEY_FIXED    = 7'h5E;
  localparam logic [KEY_W-1:0] KEY_UP_FIRST = 7'h62;
  localparam logic [KEY_W-1:0] KEY_UP_LAST  = 7'h6F;
  localparam logic [KEY_W-1:0] KEY_SH_FIRST = 7'h70;
  localparam logic [KEY_W-1:0] KEY_SH_LAST  = 7'h74;

  localparam logic [KEY_W-1:0]   UP_OFFSET    = 7'h0C;
  localparam int                 TABLE_STRIDE = 'h60;
  localparam logic [CODE_W-1:0]  FIXED_CODE   = 16'hAE00;
  localparam logic [BYTE_W-1:0]  NO_CODE_BYTE = 8'hFF;

  // Control into the code ring.
  typedef struct packed {
    logic              en;
    logic              push;
    logic              pop;
    logic [CODE_W-1:0] push_data;
  } ring_req_t;

  // Outcome of one ring operation.
  typedef struct packed {
    logic               dropped;
    logic               pop_valid;
    logic [CODE_W-1:0]  pop_data;
    logic [COUNT_W-1:0] count;
  } ring_rsp_t;

  // Table chosen by the shift status: bit 4 wins, then bit 3, then the
  // low three bits with six and seven folded down to four and five.
  function automatic logic [TSEL_W-1:0] pick_table(input logic [SHIFT_W-1:0] sh);
    logic [TSEL_W-1:0] t;
    t = sh[2:0];
    if (sh[4]) begin
      t = 3'd7;
    end else if (sh[3]) begin
      t = 3'd6;
    end else if (sh[2:1] == 2'b11) begin
      t = {2'b10, sh[0]};
    end
    return t;
  endfunction

endpackage

`default_nettype wire

/* sv/kst_store.sv */
// ----------------------------------------------------------------------------
// kst_store
// Byte-wide translation store with one write port and one registered read
// port; forms the read address from the table number and key number.
// ----------------------------------------------------------------------------
`default_nettype none

module kst_store (
  input  wire logic                        clk,
  input  wire logic                        acc,
  input  wire logic                        wr_en,
  input  wire logic [kst_pkg::TADDR_W-1:0] wr_addr,
  input  wire logic [kst_pkg::BYTE_W-1:0]  wr_data,
  input  wire logic [kst_pkg::TSEL_W-1:0]  tsel,
  input  wire logic [kst_pkg::KEY_W-1:0]   key,
  output      logic [kst_pkg::BYTE_W-1:0]  rd_data
);
  import kst_pkg::*;

  logic [BYTE_W-1:0]   mem [STORE_DEPTH];
  logic [BYTE_W-1:0]   rd_data_r;
  logic [STORE_AW-1:0] base;
  logic [KEY_W-1:0]    key_ofs;
  logic [STORE_AW-1:0] rd_idx;
  logic                wr_ok;

  // Table base is tsel * 0x60, built from two shifts.
  assign base = STORE_AW'({tsel, 6'd0}) + STORE_AW'({tsel, 5'd0});

  // Keys in the upper range index twelve entries lower in the table.
  assign key_ofs = (key >= KEY_UP_FIRST && key <= KEY_UP_LAST) ? key - UP_OFFSET : key;
  assign rd_idx  = base + STORE_AW'(key_ofs);

  assign wr_ok = (32'(wr_addr) < STORE_DEPTH);

  always_ff @(posedge clk) begin
    if (acc && wr_en && wr_ok) begin
      mem[STORE_AW'(wr_addr)] <= wr_data;
    end
    if (acc) begin
      rd_data_r <= mem[rd_idx];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

/* sv/kst_ring.sv */
// ----------------------------------------------------------------------------
// kst_ring
// Ring buffer of translated key codes with write slot, read slot and fill
// count; a push into a full ring is reported as dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module kst_ring (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire kst_pkg::ring_req_t req,
  output      kst_pkg::ring_rsp_t rsp
);
  import kst_pkg::*;

  logic [CODE_W-1:0]  ring_r [RING_DEPTH];
  logic [RING_AW-1:0] wr_r, wr_nxt;
  logic [RING_AW-1:0] rd_r, rd_nxt;
  logic [RING_CW-1:0] fill_r, fill_nxt;
  logic               full, do_push, do_pop;

  assign full    = (fill_r == RING_CW'(RING_DEPTH));
  assign do_push = req.push && !full;
  assign do_pop  = req.pop && (fill_r != '0);

  always_comb begin
    wr_nxt   = wr_r;
    rd_nxt   = rd_r;
    fill_nxt = fill_r;
    if (do_push) begin
      wr_nxt   = (wr_r == RING_AW'(RING_DEPTH - 1)) ? '0 : wr_r + 1'b1;
      fill_nxt = fill_r + 1'b1;
    end else if (do_pop) begin
      rd_nxt   = (rd_r == RING_AW'(RING_DEPTH - 1)) ? '0 : rd_r + 1'b1;
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r   <= '0;
      rd_r   <= '0;
      fill_r <= '0;
    end else if (req.en) begin
      wr_r   <= wr_nxt;
      rd_r   <= rd_nxt;
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (req.en && do_push) begin
      ring_r[wr_r] <= req.push_data;
    end
  end

  assign rsp.dropped   = req.push && full;
  assign rsp.pop_valid = do_pop;
  assign rsp.pop_data  = do_pop ? ring_r[rd_r] : '0;
  assign rsp.count     = COUNT_W'(fill_nxt);

endmodule

`default_nettype wire

/* sv/keyboard_scan_code_translator.sv */
// ----------------------------------------------------------------------------
// keyboard_scan_code_translator
// Translates keyboard make/break scan codes into 16-bit key codes through
// eight shift-selected translation tables and queues them in a ring buffer.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Ports                            | Carries
//  --------+-----------+----------------------------------+---------------------------
//  in_     | slave     | in_tvalid/tready/tdata/tuser     | key event, table write, pop
//  out_    | master    | out_tvalid/tready/tdata          | one result per transaction
//
// Each input transaction yields exactly one output transaction via stage one and
// the output register. One transaction can be taken every cycle while the output
// is not stalled; the rate is set by the single store read port, read once per item.
// Reset (rst_n low at a clock edge) empties the pipeline, the shift status and
// the code ring; the translation store keeps whatever it holds and must be
// loaded with table writes before key events read it.
// A stalled output holds its result, and the input keeps accepting as long as
// the stage in front of the output register can move.
//
`default_nettype none

module keyboard_scan_code_translator (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  output      logic                          in_tready,
  // tdata, from bit 0: scan_code[7:0], table_addr[17:8], table_data[25:18],
  // zeros[31:26].
  input  wire logic [kst_pkg::IN_DATA_W-1:0] in_tdata,
  // tuser: action[1:0].
  input  wire logic [kst_pkg::ACT_W-1:0]     in_tuser,
  output      logic                          out_tvalid,
  input  wire logic                          out_tready,
  // tdata, from bit 0: code[15:0], code_valid[16], dropped[17],
  // led_bits[20:18], table_select[23:21], key_held[24], pop_data[40:25],
  // pop_valid[41], buffer_count[46:42], zero[47].
  output      logic [kst_pkg::OUT_DATA_W-1:0] out_tdata
);
  import kst_pkg::*;

  // Input field split.
  logic [SC_W-1:0]    in_sc;
  logic [TADDR_W-1:0] in_taddr;
  logic [BYTE_W-1:0]  in_tdat;
  logic [KEY_W-1:0]   in_key;
  logic               in_acc;

  assign in_sc    = in_tdata[7:0];
  assign in_taddr = in_tdata[17:8];
  assign in_tdat  = in_tdata[25:18];
  assign in_key   = in_sc[6:0];

  // Pipeline control. Stage one holds the accepted item while the store read
  // completes; the output register holds the finished result.
  logic s1_v_r, s1_v_nxt;
  logic out_v_r, out_v_nxt;
  logic out_free, s1_adv;

  assign out_free  = !out_v_r || out_tready;
  assign s1_adv    = s1_v_r && out_free;
  assign in_tready = !s1_v_r || out_free;
  assign in_acc    = in_tvalid && in_tready;

  // The shift status depends only on scan codes, so it is brought up to date
  // at acceptance. That way the next key event reads the right table at once.
  logic [SHIFT_W-1:0] shift_r, shift_nxt;
  logic               in_shift_key;
  logic [SHIFT_W-1:0] in_shift_bit;

  assign in_shift_key = (in_key >= KEY_SH_FIRST) && (in_key <= KEY_SH_LAST);
  assign in_shift_bit = SHIFT_W'(1) << in_sc[2:0];

  always_comb begin
    shift_nxt = shift_r;
    if (in_acc && (in_tuser == ACT_KEY) && in_shift_key) begin
      if (in_sc[7]) begin
        shift_nxt = shift_r & ~in_shift_bit;
      end else begin
        shift_nxt = shift_r | in_shift_bit;
      end
    end
  end

  // Stage one payload.
  logic [ACT_W-1:0]   s1_act_r;
  logic [SC_W-1:0]    s1_sc_r;
  logic [SHIFT_W-1:0] s1_shift_r;
  logic [BYTE_W-1:0]  s1_byte;

  // The read uses the table chosen before this item; a shift key also reads the
  // store, but its byte is not used.
  kst_store u_store (
    .clk     (clk),
    .acc     (in_acc),
    .wr_en   (in_tuser == ACT_WRITE),
    .wr_addr (in_taddr),
    .wr_data (in_tdat),
    .tsel    (pick_table(shift_r)),
    .key     (in_key),
    .rd_data (s1_byte)
  );

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (in_acc) begin
      s1_v_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_v_nxt = 1'b0;
    end
  end

  always_comb begin
    out_v_nxt = out_v_r;
    if (s1_adv) begin
      out_v_nxt = 1'b1;
    end else if (out_tready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      shift_r <= '0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
      shift_r <= shift_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_act_r   <= in_tuser;
      s1_sc_r    <= in_sc;
      s1_shift_r <= shift_nxt;
    end
  end

  // Stage two: form the key code from the table byte.
  logic [KEY_W-1:0]  s1_key;
  logic              s1_make;
  logic              lo_range, up_range, fixed_key, byte_ok, high_only;
  logic              code_valid;
  logic [CODE_W-1:0] code_raw, code_out;

  assign s1_key    = s1_sc_r[6:0];
  assign s1_make   = (s1_act_r == ACT_KEY) && !s1_sc_r[7];
  assign lo_range  = (s1_key <= KEY_LO_LAST);
  assign up_range  = (s1_key >= KEY_UP_FIRST) && (s1_key <= KEY_UP_LAST);
  assign fixed_key = (s1_key == KEY_FIXED);
  assign byte_ok   = (s1_byte != NO_CODE_BYTE);
  // These keys place the table byte in the high half, like the upper range.
  assign high_only = up_range || (s1_key == KEY_LO_LAST) ||
                     (s1_key == KEY_HI_ONLY0) || (s1_key == KEY_HI_ONLY1);

  assign code_valid = s1_make && (((lo_range || up_range) && byte_ok) || fixed_key);

  always_comb begin
    if (fixed_key) begin
      code_raw = FIXED_CODE;
    end else if (high_only) begin
      code_raw = {s1_byte, 8'h00};
    end else begin
      code_raw = {1'b0, s1_key, s1_byte};
    end
  end

  assign code_out = code_valid ? code_raw : '0;

  // Code ring: pushes and pops are committed as the item leaves stage one.
  ring_req_t ring_req;
  ring_rsp_t ring_rsp;

  assign ring_req.en        = s1_adv;
  assign ring_req.push      = code_valid;
  assign ring_req.pop       = (s1_act_r == ACT_POP);
  assign ring_req.push_data = code_out;

  kst_ring u_ring (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (ring_req),
    .rsp   (ring_rsp)
  );

  // The held bit of the key just after its own event is set by a make code
  // and cleared by a break code, so it follows from the event alone.
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  assign out_data_nxt = {1'b0,
                         ring_rsp.count,
                         ring_rsp.pop_valid,
                         ring_rsp.pop_data,
                         s1_make,
                         pick_table(s1_shift_r),
                         s1_shift_r[2:0],
                         ring_rsp.dropped,
                         code_valid,
                         code_out};

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire
